// ===== design/scse_pkg.sv =====
// Shared constants, codes and interface types of the symmetric CSR element store.
`timescale 1ns / 1ps
package scse_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_ENTRIES = 16384;
    localparam int MAX_ROW_LEN = 64;

    localparam int FUNC_W = 3;
    localparam int ROW_W  = 11;
    localparam int COL_W  = 10;
    localparam int POS_W  = 15;
    localparam int VAL_W  = 64;
    localparam int ST_W   = 2;
    localparam int RS_AW  = $clog2(MAX_ROWS + 1);
    localparam int EA_W   = $clog2(MAX_ENTRIES);

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_AW     = 3;

    localparam logic [CFG_AW-1:0] REG_MATRIX_ROWS = 3'd0;

    typedef enum logic [2:0]
    {
        FN_LD_START,
        FN_LD_COL,
        FN_SET,
        FN_ADD,
        FN_GET,
        FN_CLR_ROW,
        FN_CLR_COL,
        FN_CLR_VAL
    } func_t;

    typedef enum logic [1:0]
    {
        ST_OK,
        ST_INDEX,
        ST_LOWER,
        ST_SAT
    } status_t;

    typedef enum logic [3:0]
    {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_RS0,
        S_RS1,
        S_RS2,
        S_RS3,
        S_SCAN,
        S_POST,
        S_AWR,
        S_GRD,
        S_CLR,
        S_SWEEP,
        S_DONE
    } state_t;

    typedef enum logic [1:0]
    {
        EA_FPOS,
        EA_CPTR,
        EA_SWEEP
    } ev_addr_t;

    typedef enum logic [1:0]
    {
        ED_ZERO,
        ED_VALUE,
        ED_SUM
    } ev_data_t;

    typedef struct packed
    {
        logic     accept;
        logic     rs_wr;
        logic     ci_wr;
        logic     rs_rd;
        logic     rs_rd_next;
        logic     cap_start;
        logic     span_load;
        logic     span_empty;
        logic     scan_en;
        logic     ev_rd;
        logic     ev_wr;
        ev_addr_t ev_asel;
        ev_data_t ev_dsel;
        logic     clr_init;
        logic     clr_inc;
        logic     sweep_inc;
        logic     i_clr;
        logic     i_inc;
        logic     cap_rd;
        logic     st_set;
        status_t  st_code;
        logic     out_load;
    } cmd_t;

    typedef struct packed
    {
        func_t func;
        logic  lower;
        logic  ld_start_ok;
        logic  ld_col_ok;
        logic  row_ok;
        logic  srch_done;
        logic  found;
        logic  sat;
        logic  clr_last;
        logic  sweep_last;
        logic  i_last;
    } stat_t;

endpackage

// ===== design/scse_dp.sv =====
// Datapath: pointer, index and value memories, row search, saturating add, result register.
`timescale 1ns / 1ps
module scse_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [scse_pkg::FUNC_W-1:0]      in_func,
    input  logic [scse_pkg::IN_DATA_W-1:0]   in_data,
    input  logic [scse_pkg::ROW_W-1:0]       matrix_rows,
    input  scse_pkg::cmd_t                   cmd,
    output scse_pkg::stat_t                  stat,
    output logic [scse_pkg::OUT_DATA_W-1:0]  out_data
);
    import scse_pkg::*;

    logic [VAL_W-1:0] ev_mem [0:MAX_ENTRIES-1];
    logic [COL_W-1:0] ci_mem [0:MAX_ENTRIES-1];
    logic [POS_W-1:0] rs_mem [0:MAX_ROWS];

    func_t            func_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] value_reg;

    logic [POS_W-1:0] rs_rdata_reg;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] ptr_reg;
    logic [POS_W-1:0] hi_reg;
    logic [POS_W-1:0] cmp_pos_reg;
    logic             cmp_valid_reg;
    logic [COL_W-1:0] ci_rdata_reg;
    logic             found_reg;
    logic [EA_W-1:0]  fpos_reg;
    logic [POS_W-1:0] cptr_reg;
    logic [EA_W-1:0]  sweep_reg;
    logic [COL_W-1:0] i_reg;
    logic [VAL_W-1:0] ev_rdata_reg;
    logic [VAL_W-1:0] rd_reg;
    status_t          st_reg;
    logic [VAL_W+ST_W-1:0] out_reg;

    logic [ROW_W-1:0] tgt_row;
    logic [ROW_W-1:0] tgt_col;
    logic [RS_AW-1:0] rs_raddr;
    logic [POS_W-1:0] diff;
    logic [POS_W-1:0] len_c;
    logic [POS_W:0]   end_c;
    logic [POS_W-1:0] hi_c;
    logic [POS_W-1:0] lo_c;
    logic             match;
    logic             issue;
    logic [POS_W:0]   cptr_inc;
    logic [EA_W-1:0]  ev_waddr;
    logic [VAL_W-1:0] ev_wdata;
    logic [VAL_W-1:0] sum;
    logic [VAL_W-1:0] sum_sat;
    logic             sat;

    // Search target: get mirrors the lower triangle, clear row looks for the diagonal, clear column walks the rows.
    always_comb
    begin
        tgt_row = row_reg;
        tgt_col = {1'b0, col_reg};
        case (func_reg)
            FN_GET:
            begin
                if (row_reg > {1'b0, col_reg})
                begin
                    tgt_row = {1'b0, col_reg};
                    tgt_col = row_reg;
                end
            end
            FN_CLR_ROW: tgt_col = row_reg;
            FN_CLR_COL: tgt_row = {1'b0, i_reg};
            default:    tgt_row = row_reg;
        endcase
    end

    assign rs_raddr = cmd.rs_rd_next ? RS_AW'(tgt_row) + 1'b1 : RS_AW'(tgt_row);

    // Row span from start and end pointers.
    always_comb
    begin
        diff  = rs_rdata_reg - start_reg;
        len_c = '0;
        if (rs_rdata_reg > start_reg)
            len_c = (diff > POS_W'(MAX_ROW_LEN)) ? POS_W'(MAX_ROW_LEN) : diff;
        end_c = {1'b0, start_reg} + {1'b0, len_c};
        hi_c  = (end_c > (POS_W+1)'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES) : end_c[POS_W-1:0];
        lo_c  = (start_reg > hi_c) ? hi_c : start_reg;
    end

    assign match = cmd.scan_en && cmp_valid_reg && ({1'b0, ci_rdata_reg} == tgt_col);
    assign issue = cmd.scan_en && (ptr_reg < hi_reg) && !match;
    assign cptr_inc = {1'b0, cptr_reg} + 1'b1;

    assign sum = ev_rdata_reg + value_reg;
    assign sat = (ev_rdata_reg[VAL_W-1] == value_reg[VAL_W-1])
              && (sum[VAL_W-1] != ev_rdata_reg[VAL_W-1]);
    assign sum_sat = sat ? {ev_rdata_reg[VAL_W-1] ? 1'b1 : 1'b0,
                            {(VAL_W-1){~ev_rdata_reg[VAL_W-1]}}} : sum;

    always_comb
    begin
        case (cmd.ev_asel)
            EA_CPTR:  ev_waddr = cptr_reg[EA_W-1:0];
            EA_SWEEP: ev_waddr = sweep_reg;
            default:  ev_waddr = fpos_reg;
        endcase
        case (cmd.ev_dsel)
            ED_VALUE: ev_wdata = value_reg;
            ED_SUM:   ev_wdata = sum_sat;
            default:  ev_wdata = '0;
        endcase
    end

    // Memories.
    always_ff @(posedge clk)
    begin
        if (cmd.rs_wr)
            rs_mem[row_reg] <= pos_reg;
        if (cmd.rs_rd || cmd.rs_rd_next)
            rs_rdata_reg <= rs_mem[rs_raddr];
        if (cmd.ci_wr)
            ci_mem[pos_reg[EA_W-1:0]] <= col_reg;
        if (issue)
            ci_rdata_reg <= ci_mem[ptr_reg[EA_W-1:0]];
        if (cmd.ev_wr)
            ev_mem[ev_waddr] <= ev_wdata;
        if (cmd.ev_rd)
            ev_rdata_reg <= ev_mem[fpos_reg];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg   <= in_data[10:0];
            col_reg   <= in_data[20:11];
            pos_reg   <= in_data[35:21];
            value_reg <= in_data[99:36];
        end
        if (cmd.cap_start)
            start_reg <= rs_rdata_reg;
        if (cmd.span_load)
        begin
            ptr_reg <= lo_c;
            hi_reg  <= hi_c;
        end
        else if (cmd.span_empty)
        begin
            ptr_reg <= '0;
            hi_reg  <= '0;
        end
        else if (issue)
            ptr_reg <= ptr_reg + 1'b1;
        if (cmd.scan_en)
            cmp_pos_reg <= ptr_reg;
        if (cmd.scan_en && stat.srch_done)
            fpos_reg <= cmp_pos_reg[EA_W-1:0];
        if (cmd.clr_init)
            cptr_reg <= {1'b0, fpos_reg};
        else if (cmd.clr_inc)
            cptr_reg <= cptr_inc[POS_W-1:0];
        if (cmd.i_clr)
            i_reg <= '0;
        else if (cmd.i_inc)
            i_reg <= i_reg + 1'b1;
        if (cmd.accept)
            rd_reg <= '0;
        else if (cmd.cap_rd)
            rd_reg <= ev_rdata_reg;
        if (cmd.out_load)
            out_reg <= {st_reg, rd_reg};
    end

    // Control-related registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg      <= FN_LD_START;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            sweep_reg     <= '0;
            st_reg        <= ST_OK;
        end
        else
        begin
            if (cmd.accept)
                func_reg <= func_t'(in_func);
            if (cmd.span_load || cmd.span_empty)
                cmp_valid_reg <= 1'b0;
            else if (cmd.scan_en)
                cmp_valid_reg <= issue;
            if (cmd.scan_en && stat.srch_done)
                found_reg <= match;
            if (cmd.sweep_inc)
                sweep_reg <= sweep_reg + 1'b1;
            if (cmd.accept)
                st_reg <= ST_OK;
            else if (cmd.st_set)
                st_reg <= cmd.st_code;
        end
    end

    always_comb
    begin
        stat.func        = func_reg;
        stat.lower       = row_reg > {1'b0, col_reg};
        stat.ld_start_ok = row_reg <= ROW_W'(MAX_ROWS);
        stat.ld_col_ok   = pos_reg < POS_W'(MAX_ENTRIES);
        stat.row_ok      = (tgt_row < matrix_rows) && (tgt_row < ROW_W'(MAX_ROWS));
        stat.srch_done   = match || (!cmp_valid_reg && (ptr_reg >= hi_reg));
        stat.found       = found_reg;
        stat.sat         = sat;
        stat.clr_last    = cptr_inc >= {1'b0, hi_reg};
        stat.sweep_last  = sweep_reg == EA_W'(MAX_ENTRIES - 1);
        stat.i_last      = i_reg == col_reg;
    end

    assign out_data = {{(OUT_DATA_W-VAL_W-ST_W){1'b0}}, out_reg};

endmodule

// ===== design/scse_ctrl.sv =====
// Controller: sequences decode, row search, value update, sweeps and result hand-off.
`timescale 1ns / 1ps
module scse_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  scse_pkg::stat_t stat,
    output scse_pkg::cmd_t  cmd
);
    import scse_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.ev_wr     = 1'b1;
                cmd.ev_asel   = EA_SWEEP;
                cmd.sweep_inc = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RS0;
                unique case (stat.func)
                    FN_LD_START:
                    begin
                        state_next = S_DONE;
                        if (stat.ld_start_ok)
                            cmd.rs_wr = 1'b1;
                        else
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_INDEX;
                        end
                    end
                    FN_LD_COL:
                    begin
                        state_next = S_DONE;
                        if (stat.ld_col_ok)
                            cmd.ci_wr = 1'b1;
                        else
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_INDEX;
                        end
                    end
                    FN_SET, FN_ADD:
                    begin
                        if (stat.lower)
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_LOWER;
                            state_next  = S_DONE;
                        end
                    end
                    FN_CLR_COL: cmd.i_clr = 1'b1;
                    FN_CLR_VAL: state_next = S_SWEEP;
                    default:    state_next = S_RS0;
                endcase
            end
            S_RS0:
            begin
                if (stat.row_ok)
                begin
                    cmd.rs_rd  = 1'b1;
                    state_next = S_RS1;
                end
                else
                begin
                    cmd.span_empty = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_RS1:
            begin
                // Start pointer is in the read register now; fetch the end pointer.
                cmd.rs_rd_next = 1'b1;
                cmd.cap_start  = 1'b1;
                state_next     = S_RS2;
            end
            S_RS2:
            begin
                state_next = S_RS3;
            end
            S_RS3:
            begin
                cmd.span_load = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (stat.srch_done)
                    state_next = S_POST;
            end
            S_POST:
            begin
                state_next = S_DONE;
                unique case (stat.func)
                    FN_SET:
                    begin
                        if (stat.found)
                        begin
                            cmd.ev_wr   = 1'b1;
                            cmd.ev_dsel = ED_VALUE;
                        end
                        else
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_INDEX;
                        end
                    end
                    FN_ADD:
                    begin
                        if (stat.found)
                        begin
                            cmd.ev_rd  = 1'b1;
                            state_next = S_AWR;
                        end
                        else
                        begin
                            cmd.st_set  = 1'b1;
                            cmd.st_code = ST_INDEX;
                        end
                    end
                    FN_GET:
                    begin
                        if (stat.found)
                        begin
                            cmd.ev_rd  = 1'b1;
                            state_next = S_GRD;
                        end
                    end
                    FN_CLR_ROW:
                    begin
                        if (stat.found)
                        begin
                            cmd.clr_init = 1'b1;
                            state_next   = S_CLR;
                        end
                    end
                    FN_CLR_COL:
                    begin
                        if (stat.found)
                            cmd.ev_wr = 1'b1;
                        if (!stat.i_last)
                        begin
                            cmd.i_inc  = 1'b1;
                            state_next = S_RS0;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_AWR:
            begin
                cmd.ev_wr   = 1'b1;
                cmd.ev_dsel = ED_SUM;
                if (stat.sat)
                begin
                    cmd.st_set  = 1'b1;
                    cmd.st_code = ST_SAT;
                end
                state_next = S_DONE;
            end
            S_GRD:
            begin
                cmd.cap_rd = 1'b1;
                state_next = S_DONE;
            end
            S_CLR:
            begin
                cmd.ev_wr   = 1'b1;
                cmd.ev_asel = EA_CPTR;
                cmd.clr_inc = 1'b1;
                if (stat.clr_last)
                    state_next = S_DONE;
            end
            S_SWEEP:
            begin
                cmd.ev_wr     = 1'b1;
                cmd.ev_asel   = EA_SWEEP;
                cmd.sweep_inc = 1'b1;
                if (stat.sweep_last)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/symmetric_csr_element_store_top.sv =====
// Top level of the symmetric CSR element store: stream ports, APB register, controller and datapath.
// Loads and lower-triangle writes go from decode to the result; set, add and get read the row's
//   two pointers and search its column indexes (one per cycle, at most 64); get and add then read
//   the value; clear row zeroes the entries from the diagonal to the row end; clear column repeats
//   the search for each row 0..col; clear values sweeps the value memory. Throughput: one item at
//   a time, the next taken in the cycle after the result loads. Reset: asynchronous, active low; a
//   clearing pass zeroes the value memory before the first item. APB writes are taken at any time.
`timescale 1ns / 1ps
module symmetric_csr_element_store_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Input item: tuser = func[2:0]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [scse_pkg::IN_DATA_W-1:0]     s_tdata,   // row[10:0], col[20:11], pos[35:21], value[99:36]
    input  logic [scse_pkg::FUNC_W-1:0]        s_tuser,   // func[2:0]
    // Result item
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [scse_pkg::OUT_DATA_W-1:0]    m_tdata,   // read_value[63:0], status[65:64]
    // Register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [scse_pkg::CFG_AW-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import scse_pkg::*;

    logic [ROW_W-1:0] matrix_rows_reg;
    cmd_t             cmd;
    stat_t            stat;

    // Register write on the access phase; the port never stalls.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            matrix_rows_reg <= '0;
        else if (psel && penable && pwrite && pready && (paddr == REG_MATRIX_ROWS))
            matrix_rows_reg <= pwdata[ROW_W-1:0];
    end

    // Read back the row count; other addresses read as zero.
    assign prdata = (paddr == REG_MATRIX_ROWS) ? {{(32-ROW_W){1'b0}}, matrix_rows_reg} : '0;

    // The controller owns the handshakes and sequencing; the datapath owns storage.
    scse_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    scse_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_func     (s_tuser),
        .in_data     (s_tdata),
        .matrix_rows (matrix_rows_reg),
        .cmd         (cmd),
        .stat        (stat),
        .out_data    (m_tdata)
    );

endmodule

// ===== design/scse_chk.sv =====
// Port-level checker for the symmetric CSR element store, bound to the top level.
`timescale 1ns / 1ps
module scse_chk
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [scse_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [31:0]                      prdata,
    input logic                             pready
);
    import scse_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Taking an item closes the input until it is worked through.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // Only get returns a value, and get never reports an error.
    a_get_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[63:0] != '0) |-> m_tdata[65:64] == ST_OK)
        else $error("nonzero read value with nonzero status");

    a_prdata: assert property (@(posedge clk) disable iff (!rst_n)
        pready && (prdata[31:ROW_W] == '0))
        else $error("register port stalled or read data out of range");

endmodule

bind symmetric_csr_element_store_top scse_chk u_scse_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .prdata   (prdata),
    .pready   (pready)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench of the symmetric CSR element store: stream, register and scoreboard.
`timescale 1ns / 1ps
module tb_top;
    import scse_pkg::*;

    // Clock, reset and block ports
    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    symmetric_csr_element_store_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // One expected result item
    typedef struct
    {
        logic [63:0] rd;
        status_t     st;
        func_t       fn;
    } result_t;

    result_t     expected_results[$];
    int          mismatch_cnt;
    int          items_sent;
    int          results_seen;
    int          status_cnt[4];
    bit          hold_req;
    bit          run_done;

    // Shadow copy of the matrix structure and values
    bit [14:0]   shadow_start[0:MAX_ROWS];
    bit          start_known[0:MAX_ROWS];
    bit [9:0]    shadow_col[0:MAX_ENTRIES-1];
    bit          col_known[0:MAX_ENTRIES-1];
    logic [63:0] shadow_val[0:MAX_ENTRIES-1];
    bit [10:0]   shadow_rows;

    localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Searched span [lo, hi) of row r; 0 if the row is not in use.
    function automatic bit row_bounds(input int r, output int lo, output int hi);
        int s;
        int e;
        int len;
        lo = 0;
        hi = 0;
        if (r >= shadow_rows || r >= MAX_ROWS)
            return 0;
        s = shadow_start[r];
        e = shadow_start[r + 1];
        len = (e > s) ? e - s : 0;
        if (len > MAX_ROW_LEN)
            len = MAX_ROW_LEN;
        e = s + len;
        if (e > MAX_ENTRIES)
            e = MAX_ENTRIES;
        if (s > e)
            s = e;
        lo = s;
        hi = e;
        return 1;
    endfunction

    function automatic int locate(input int r, input int c);
        int lo;
        int hi;
        if (!row_bounds(r, lo, hi))
            return -1;
        for (int p = lo; p < hi; p++)
            if (int'(shadow_col[p]) == c)
                return p;
        return -1;
    endfunction

    // True when a search of row r touches only pointers and indexes already loaded.
    function automatic bit row_loaded(input int r);
        int lo;
        int hi;
        if (r >= shadow_rows || r >= MAX_ROWS)
            return 1;
        if (!start_known[r] || !start_known[r + 1])
            return 0;
        void'(row_bounds(r, lo, hi));
        for (int p = lo; p < hi; p++)
            if (!col_known[p])
                return 0;
        return 1;
    endfunction

    function automatic bit item_legal(input func_t fn, input int row, input int col);
        case (fn)
            FN_SET, FN_ADD: return (row > col) ? 1'b1 : row_loaded(row);
            FN_GET:         return row_loaded((row > col) ? col : row);
            FN_CLR_ROW:     return row_loaded(row);
            FN_CLR_COL:
            begin
                for (int i = 0; i <= col; i++)
                    if (!row_loaded(i))
                        return 0;
                return 1;
            end
            default:        return 1;
        endcase
    endfunction

    // Apply one item to the shadow state and return its expected result.
    function automatic result_t apply_item(input func_t fn, input int row, input int col,
                                           input int pos, input logic [63:0] val);
        result_t     res;
        int          p;
        int          lo;
        int          hi;
        logic [63:0] sum;
        res.rd = '0;
        res.st = ST_OK;
        res.fn = fn;
        case (fn)
            FN_LD_START:
                if (row <= MAX_ROWS)
                begin
                    shadow_start[row] = pos;
                    start_known[row] = 1;
                end
                else
                    res.st = ST_INDEX;
            FN_LD_COL:
                if (pos < MAX_ENTRIES)
                begin
                    shadow_col[pos] = col;
                    col_known[pos] = 1;
                end
                else
                    res.st = ST_INDEX;
            FN_SET, FN_ADD:
                if (row > col)
                    res.st = ST_LOWER;
                else
                begin
                    p = locate(row, col);
                    if (p < 0)
                        res.st = ST_INDEX;
                    else if (fn == FN_SET)
                        shadow_val[p] = val;
                    else
                    begin
                        sum = shadow_val[p] + val;
                        if (shadow_val[p][63] == val[63] && sum[63] != val[63])
                        begin
                            sum = val[63] ? Q_MIN : Q_MAX;
                            res.st = ST_SAT;
                        end
                        shadow_val[p] = sum;
                    end
                end
            FN_GET:
            begin
                p = (row > col) ? locate(col, row) : locate(row, col);
                if (p >= 0)
                    res.rd = shadow_val[p];
            end
            FN_CLR_ROW:
            begin
                p = locate(row, row);
                if (p >= 0 && row_bounds(row, lo, hi))
                    for (int k = p; k < hi; k++)
                        shadow_val[k] = '0;
            end
            FN_CLR_COL:
                for (int i = 0; i <= col; i++)
                begin
                    p = locate(i, col);
                    if (p >= 0)
                        shadow_val[p] = '0;
                end
            default:
                for (int k = 0; k < MAX_ENTRIES; k++)
                    shadow_val[k] = '0;
        endcase
        return res;
    endfunction

    // Drive one item, wait for its acceptance and queue what it should produce.
    task automatic send_item(input func_t fn, input int row, input int col, input int pos,
                             input logic [63:0] val);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {4'b0, val, pos[14:0], col[9:0], row[10:0]};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.insert(expected_results.size(), apply_item(fn, row, col, pos, val));
        items_sent++;
    endtask

    // Drop valid and wait until every result is back, then let the block settle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // APB write of the row count, then read it back.
    task automatic write_rows(input int n);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_MATRIX_ROWS;
        pwdata  <= n & 32'h7FF;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow_rows = n[10:0];
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[10:0] !== shadow_rows)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("register readback: expected %0d, got %0d", shadow_rows, prdata[10:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] pick_value;
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            4:       return 64'($signed($urandom_range(0, 2000)) - 1000) <<< 32;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Load pointers and column indexes of n rows, entries starting at base.
    task automatic load_layout(input int n, input int base);
        int cursor;
        int len;
        int c;
        cursor = base;
        for (int r = 0; r <= n; r++)
        begin
            send_item(FN_LD_START, r, $urandom_range(0, 1023), cursor, pick_value());
            if (r < n)
            begin
                len = ($urandom_range(0, 15) == 0) ? 70 : $urandom_range(0, 6);
                for (int k = 0; k < len; k++)
                begin
                    if (k == 0 && $urandom_range(0, 9) < 7)
                        c = r;
                    else if ($urandom_range(0, 9) == 0)
                        c = $urandom_range(0, r);
                    else
                        c = $urandom_range(r, (r + 40 > 1023) ? 1023 : r + 40);
                    send_item(FN_LD_COL, $urandom_range(0, 2047), c, cursor, pick_value());
                    cursor++;
                end
            end
        end
    endtask

    // One random item, mostly aimed at stored elements of the first n rows.
    task automatic random_item(input int n);
        int    sel;
        int    row;
        int    col;
        int    pos;
        int    lo;
        int    hi;
        func_t fn;
        sel = $urandom_range(0, 99);
        row = $urandom_range(0, 2047);
        col = $urandom_range(0, 1023);
        pos = $urandom_range(0, 32767);
        fn  = func_t'($urandom_range(FN_SET, FN_GET));
        if (sel < 55 && n > 0)
        begin
            row = $urandom_range(0, n - 1);
            if (row_bounds(row, lo, hi) && hi > lo)
                col = shadow_col[$urandom_range(lo, hi - 1)];
            else
                col = $urandom_range(row, row + 3);
            if (fn == FN_GET && $urandom_range(0, 1))
            begin
                pos = row;
                row = col;
                col = pos;
            end
        end
        else if (sel < 75)
        begin
            row = $urandom_range(0, n + 2);
            col = $urandom_range(0, n + 2);
        end
        else if (sel < 82)
        begin
            fn  = FN_CLR_ROW;
            row = $urandom_range(0, n + 2);
        end
        else if (sel < 88)
        begin
            fn  = FN_CLR_COL;
            col = $urandom_range(0, n + 2);
        end
        else if (sel == 88)
            fn = FN_CLR_VAL;
        else if (sel < 93)
            fn = func_t'($urandom_range(FN_LD_START, FN_LD_COL));
        else if (sel < 96)
            fn = func_t'($urandom_range(FN_SET, FN_CLR_ROW));
        if (fn == FN_LD_START && row <= n + 1)
            row = row + MAX_ROWS;           // keep the layout intact
        if (fn == FN_LD_COL && pos < MAX_ENTRIES)
            pos = pos + MAX_ENTRIES;
        if (!item_legal(fn, row, col))
        begin
            fn  = FN_LD_COL;
            pos = MAX_ENTRIES + $urandom_range(0, 16383);
        end
        send_item(fn, row, col, pos, pick_value());
    endtask

    // Hand-built matrix: saturation, mirror, lower triangle, duplicates, clears.
    task automatic test_directed;
        write_rows(4);
        // row 0: cols 0,1,3; row 1: cols 1,1 (duplicate); row 2 empty; row 3: col 1023
        send_item(FN_LD_START, 0, 0, 0, '0);
        send_item(FN_LD_COL, 0, 0, 0, '0);
        send_item(FN_LD_COL, 0, 1, 1, '0);
        send_item(FN_LD_COL, 0, 3, 2, '0);
        send_item(FN_LD_START, 1, 0, 3, '0);
        send_item(FN_LD_COL, 0, 1, 3, '0);
        send_item(FN_LD_COL, 0, 1, 4, '0);
        send_item(FN_LD_START, 2, 0, 5, '0);
        send_item(FN_LD_START, 3, 0, 5, '0);
        send_item(FN_LD_COL, 0, 1023, 5, '0);
        send_item(FN_LD_START, 4, 0, 6, '0);
        send_item(FN_SET, 0, 1, 0, Q_MAX);
        send_item(FN_ADD, 0, 1, 0, 64'd1);
        send_item(FN_SET, 0, 3, 0, Q_MIN);
        send_item(FN_ADD, 0, 3, 0, '1);
        send_item(FN_GET, 1, 0, 0, '0);
        send_item(FN_SET, 1, 0, 0, 64'd5);
        send_item(FN_SET, 0, 2, 0, 64'd5);
        send_item(FN_GET, 0, 2, 0, '0);
        send_item(FN_ADD, 1, 1, 0, 64'h1_0000_0000);
        send_item(FN_GET, 1, 1, 0, '0);
        send_item(FN_SET, 3, 1023, 0, 64'h7);
        send_item(FN_GET, 1023, 3, 0, '0);
        send_item(FN_GET, 1024, 5, 0, '0);
        send_item(FN_CLR_ROW, 2, 0, 0, '0);
        send_item(FN_CLR_ROW, 0, 0, 0, '0);
        send_item(FN_CLR_COL, 0, 1, 0, '0);
        send_item(FN_LD_START, 1025, 0, 0, '0);
        send_item(FN_LD_COL, 0, 0, MAX_ENTRIES, '0);
        send_item(FN_CLR_VAL, 0, 0, 0, '0);
        send_item(FN_GET, 3, 1023, 0, '0);
        drain();
    endtask

    // Row at the very end of the entry store, and a row whose end lies below its start.
    task automatic test_store_end;
        write_rows(2);
        send_item(FN_LD_START, 0, 0, 16382, '0);
        send_item(FN_LD_START, 1, 0, 16390, '0);
        send_item(FN_LD_START, 2, 0, 3, '0);
        send_item(FN_LD_COL, 0, 0, 16382, '0);
        send_item(FN_LD_COL, 0, 5, 16383, '0);
        send_item(FN_SET, 0, 5, 0, 64'h1234_5678_9ABC_DEF0);
        send_item(FN_GET, 5, 0, 0, '0);
        send_item(FN_SET, 1, 1, 0, 64'h1);
        send_item(FN_CLR_ROW, 0, 0, 0, '0);
        send_item(FN_GET, 0, 5, 0, '0);
        drain();
    endtask

    task automatic test_random(input int rows, input int rebuild, input int count);
        write_rows(rows);
        if (rebuild > 0)
            load_layout(rebuild, $urandom_range(0, 8000));
        for (int k = 0; k < count; k++)
            random_item(rebuild > 0 ? rebuild : 12);
        drain();
    endtask

    // Stall the result side for a long stretch while items keep coming.
    task automatic test_backpressure;
        hold_req = 1;
        for (int k = 0; k < 20; k++)
            random_item(12);
        drain();
    endtask

    // Result side: random stalls, long hold-off on request, field-wise compare.
    initial
    begin
        result_t exp_res;
        int      stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                for (int c = 0; c < 400; c++)
                    @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                stall = $urandom_range(0, 7);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen++;
            status_cnt[m_tdata[65:64]]++;
            if (expected_results.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("result with nothing expected: %h", m_tdata);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (m_tdata[63:0] !== exp_res.rd || m_tdata[65:64] !== exp_res.st)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%s: expected value %h status %s, got value %h status %0d",
                                 exp_res.fn.name(), exp_res.rd, exp_res.st.name(),
                                 m_tdata[63:0], m_tdata[65:64]);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        hold_req = 0;
        mismatch_cnt = 0;
        items_sent   = 0;
        results_seen = 0;
        shadow_rows  = '0;
        for (int k = 0; k <= MAX_ROWS; k++)
            start_known[k] = 0;
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            col_known[k]  = 0;
            shadow_val[k] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_store_end();
        test_random(0, 0, 60);
        test_random(12, 12, 350);
        test_backpressure();
        test_random(1024, 0, 250);
        test_random(7, 7, 1050 - items_sent > 50 ? 1050 - items_sent : 50);

        $display("ran %0d items, %0d results: ok %0d, index %0d, lower %0d, saturated %0d",
                 items_sent, results_seen, status_cnt[0], status_cnt[1], status_cnt[2],
                 status_cnt[3]);
        $display("row counts 0, 2, 4, 7, 12 and 1024 used; %0d mismatches", mismatch_cnt);
        if (mismatch_cnt == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("timeout, %0d results still expected", expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
design/scse_pkg.sv
design/scse_dp.sv
design/scse_ctrl.sv
design/symmetric_csr_element_store_top.sv
design/scse_chk.sv
tb/tb_top.sv
